// ===== rtl/cpi_pkg.sv =====
`timescale 1ns / 1ps

package cpi_pkg;

  // Output field widths, fixed by the stream format
  localparam int unsigned INDEX_W  = 6;
  localparam int unsigned SYMBOL_W = 8;
  localparam int unsigned COUNT_W  = 7;

  // Character code of palette index zero ('A')
  localparam logic [SYMBOL_W-1:0] SYMBOL_BASE = 8'd65;

  // Pixel payload as it walks down the chain
  typedef struct packed {
    logic       start_image;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Per-token status bits as it walks down the chain
  typedef struct packed {
    logic valid;  // a pixel occupies this slot
    logic found;  // matched or claimed an entry upstream
    logic added;  // claimed a fresh entry upstream
  } tok_stat_t;

endpackage

// ===== rtl/color_palette_indexer.sv =====
`timescale 1ns / 1ps
// Each pixel passes through the register of every palette cell, then the output register, before out_tvalid.
// Throughput: one pixel per cycle while the chain advances; each pixel walks the chain of PALETTE_SIZE
//   cells, one cell per cycle, directly behind the pixel before it.
// The chain stalls as a whole while a result waits and the last cell holds a pixel.
// Reset (rst_n low, synchronous) empties the palette by clearing the cells'
//   fill markers; entry contents are not cleared and no clearing pass is needed.

module color_palette_indexer import cpi_pkg::*; #(
  parameter int unsigned PALETTE_SIZE = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tuser,   // start_image
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // palette_index[5:0], symbol_code[13:6],
                                  // color_count[20:14], zero[23:21]
  output logic [1:0]  out_tuser   // new_color[0], overflow[1]
);

  localparam int unsigned IDX_W = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(PALETTE_SIZE + 1);

  tok_stat_t        stat_c [PALETTE_SIZE+1];
  pix_t             pix_c  [PALETTE_SIZE+1];
  logic [IDX_W-1:0] idx_c  [PALETTE_SIZE+1];
  logic [CNT_W-1:0] cnt_c  [PALETTE_SIZE+1];

  logic adv, out_load;

  logic                    out_valid_r;
  logic [23:0]             out_data_r, out_data_nxt;
  logic [1:0]              out_user_r, out_user_nxt;
  logic [IDX_W+INDEX_W-1:0] idx_ext;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;
  logic [INDEX_W-1:0]      pal_idx;
  logic [SYMBOL_W-1:0]     sym;
  logic [COUNT_W-1:0]      cnt_out;

  // Chain moves when the output register can take the last cell or it is empty
  assign out_load  = ~out_valid_r | out_tready;
  assign adv       = out_load | ~stat_c[PALETTE_SIZE].valid;
  assign in_tready = adv;

  // Head of the chain: a fresh token
  always_comb begin
    stat_c[0]             = '0;
    stat_c[0].valid       = in_tvalid;
    pix_c[0].start_image  = in_tuser;
    pix_c[0].red          = in_tdata[7:0];
    pix_c[0].green        = in_tdata[15:8];
    pix_c[0].blue         = in_tdata[23:16];
    idx_c[0]              = '0;
    cnt_c[0]              = '0;
  end

  // Row of palette cells
  for (genvar k = 0; k < PALETTE_SIZE; k++) begin : g_cell
    cpi_cell #(
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W),
      .CELL_IDX (k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .stat_in  (stat_c[k]),
      .pix_in   (pix_c[k]),
      .idx_in   (idx_c[k]),
      .cnt_in   (cnt_c[k]),
      .stat_out (stat_c[k+1]),
      .pix_out  (pix_c[k+1]),
      .idx_out  (idx_c[k+1]),
      .cnt_out  (cnt_c[k+1])
    );
  end

  // Result formatting; a token that found no place is an overflow
  always_comb begin
    idx_ext = {{INDEX_W{1'b0}}, idx_c[PALETTE_SIZE]};
    cnt_ext = {{COUNT_W{1'b0}}, cnt_c[PALETTE_SIZE]};
    pal_idx = stat_c[PALETTE_SIZE].found ? idx_ext[INDEX_W-1:0] : '0;
    sym     = SYMBOL_BASE + {{(SYMBOL_W-INDEX_W){1'b0}}, pal_idx};
    cnt_out = cnt_ext[COUNT_W-1:0];
    out_data_nxt = {3'b000, cnt_out, sym, pal_idx};
    out_user_nxt = {~stat_c[PALETTE_SIZE].found, stat_c[PALETTE_SIZE].added};
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= stat_c[PALETTE_SIZE].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== rtl/cpi_cell.sv =====
`timescale 1ns / 1ps

module cpi_cell import cpi_pkg::*; #(
  parameter int unsigned IDX_W    = 6,
  parameter int unsigned CNT_W    = 7,
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  tok_stat_t        stat_in,
  input  pix_t             pix_in,
  input  logic [IDX_W-1:0] idx_in,
  input  logic [CNT_W-1:0] cnt_in,
  output tok_stat_t        stat_out,
  output pix_t             pix_out,
  output logic [IDX_W-1:0] idx_out,
  output logic [CNT_W-1:0] cnt_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(CELL_IDX + 1);

  // One palette entry and its fill marker (thermometer bit of the entry count)
  logic [23:0]      entry_r;
  logic             fill_r, fill_nxt;
  tok_stat_t        stat_r, stat_nxt;
  pix_t             pix_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic occ_eff, hit, claim, occ_after;

  // Compare / claim decision for the token passing this cell
  always_comb begin
    occ_eff   = fill_r & ~pix_in.start_image;
    hit       = stat_in.valid & ~stat_in.found & occ_eff &
                (entry_r == {pix_in.red, pix_in.green, pix_in.blue});
    claim     = stat_in.valid & ~stat_in.found & ~occ_eff;
    occ_after = occ_eff | claim;

    fill_nxt       = stat_in.valid ? occ_after : fill_r;
    stat_nxt       = stat_in;
    stat_nxt.found = stat_in.found | hit | claim;
    stat_nxt.added = stat_in.added | claim;
    idx_nxt        = (hit || claim) ? MY_IDX : idx_in;
    cnt_nxt        = occ_after ? MY_CNT : cnt_in;
  end

  // Control state: fill marker and token status (slot valid, found, added)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 1'b0;
      stat_r <= '0;
    end else if (adv) begin
      fill_r <= fill_nxt;
      stat_r <= stat_nxt;
    end
  end

  // Payload: entry write on claim, token hand-off to the next cell
  always_ff @(posedge clk) begin
    if (adv) begin
      if (claim) begin
        entry_r <= {pix_in.red, pix_in.green, pix_in.blue};
      end
      pix_r <= pix_in;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign stat_out = stat_r;
  assign pix_out  = pix_r;
  assign idx_out  = idx_r;
  assign cnt_out  = cnt_r;

endmodule

// ===== rtl/cpi_checker.sv =====
`timescale 1ns / 1ps

module cpi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // Overflow and new color never come together
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("new_color and overflow both set");

  // Overflow reports index zero
  a_ovf_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[5:0] == 6'd0)
    else $error("overflow with nonzero index");

  // Symbol tracks the index
  a_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[13:6] == ({2'b00, out_tdata[5:0]} + 8'd65))
    else $error("symbol code does not match index");

  // A new color leaves the index below the count
  a_new_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> {1'b0, out_tdata[5:0]} < out_tdata[20:14])
    else $error("new color index not below count");

endmodule

bind color_palette_indexer cpi_checker u_cpi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
